>>> design/sdiv_pkg.sv
// ----------------------------------------------------------------------------
// sdiv_pkg
// shared constants and types for the signed restoring divider pipeline
// ----------------------------------------------------------------------------
package sdiv_pkg;

   // default operand width in bits
   localparam int WIDTH_DEFAULT = 32;

   // control bits that travel with each item down the pipeline
   typedef struct packed {
      logic valid;     // stage holds a live item
      logic negative;  // exactly one operand negative
      logic zero_div;  // divisor was zero
   } ctrl_type;

endpackage

>>> design/sdiv_prep.sv
// ----------------------------------------------------------------------------
// sdiv_prep
// input stage: operand magnitudes, result sign and zero divisor detect
// ----------------------------------------------------------------------------
module sdiv_prep #(
   parameter int WIDTH = sdiv_pkg::WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     take,
   input  logic signed [WIDTH-1:0]  dividend,
   input  logic signed [WIDTH-1:0]  divisor,
   output sdiv_pkg::ctrl_type       ctrl_out,
   output logic        [WIDTH-1:0]  a_out,
   output logic        [WIDTH-1:0]  b_out
);

   sdiv_pkg::ctrl_type ctrl_ff, ctrl_in;
   logic [WIDTH-1:0]   a_ff, a_in;
   logic [WIDTH-1:0]   b_ff, b_in;
   logic               neg_a, neg_b;

   always_comb begin
      neg_a            = dividend[WIDTH-1];
      neg_b            = divisor[WIDTH-1];
      // two's complement magnitude, minimum maps to 2^(WIDTH-1)
      a_in             = neg_a ? (~dividend + 1'b1) : dividend;
      b_in             = neg_b ? (~divisor + 1'b1) : divisor;
      ctrl_in.valid    = take;
      ctrl_in.negative = neg_a ^ neg_b;
      ctrl_in.zero_div = (divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;

endmodule

>>> design/sdiv_stage.sv
// ----------------------------------------------------------------------------
// sdiv_stage
// one restoring step: shift in one dividend bit, trial subtract, keep or restore
// ----------------------------------------------------------------------------
module sdiv_stage #(
   parameter int WIDTH = sdiv_pkg::WIDTH_DEFAULT,
   parameter int BIT   = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  sdiv_pkg::ctrl_type  prev_ctrl,
   input  logic [WIDTH-1:0]    prev_rem,
   input  logic [WIDTH-1:0]    prev_a,
   input  logic [WIDTH-1:0]    prev_b,
   input  logic [WIDTH-1:0]    prev_q,
   output sdiv_pkg::ctrl_type  ctrl_out,
   output logic [WIDTH-1:0]    rem_out,
   output logic [WIDTH-1:0]    a_out,
   output logic [WIDTH-1:0]    b_out,
   output logic [WIDTH-1:0]    q_out
);

   sdiv_pkg::ctrl_type ctrl_ff;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   a_ff;
   logic [WIDTH-1:0]   b_ff;
   logic [WIDTH-1:0]   q_ff, q_in;
   logic [WIDTH:0]     shifted;
   logic [WIDTH:0]     diff;
   logic               fits;

   always_comb begin
      shifted  = {prev_rem, prev_a[BIT]};
      diff     = shifted - {1'b0, prev_b};
      fits     = (shifted >= {1'b0, prev_b});
      rem_in   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      q_in     = prev_q;
      q_in[BIT] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= prev_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         a_ff   <= prev_a;
         b_ff   <= prev_b;
         q_ff   <= q_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign q_out    = q_ff;

endmodule

>>> design/sdiv_post.sv
// ----------------------------------------------------------------------------
// sdiv_post
// output stage: apply sign, clamp to signed range, hold result for transfer
// ----------------------------------------------------------------------------
module sdiv_post #(
   parameter int WIDTH = sdiv_pkg::WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  sdiv_pkg::ctrl_type       prev_ctrl,
   input  logic        [WIDTH-1:0]  prev_q,
   output logic                     valid_out,
   output logic signed [WIDTH-1:0]  quotient_out,
   output logic                     saturated_out,
   output logic                     zero_div_out
);

   localparam logic [WIDTH-1:0] TOP_BIT = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

   logic             valid_ff;
   logic [WIDTH-1:0] quotient_ff, quotient_in;
   logic             saturated_ff, saturated_in;
   logic             zero_div_ff;

   always_comb begin
      if (prev_ctrl.negative) begin
         saturated_in = (prev_q > TOP_BIT);
         quotient_in  = saturated_in ? TOP_BIT : (~prev_q + 1'b1);
      end else begin
         saturated_in = (prev_q > MAX_POS);
         quotient_in  = saturated_in ? MAX_POS : prev_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff  <= quotient_in;
         saturated_ff <= saturated_in;
         zero_div_ff  <= prev_ctrl.zero_div;
      end
   end

   assign valid_out     = valid_ff;
   assign quotient_out  = quotient_ff;
   assign saturated_out = saturated_ff;
   assign zero_div_out  = zero_div_ff;

endmodule

>>> design/signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider
// pipelined signed divider, quotient truncated toward zero and saturated
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid/req_ready with req_dividend and req_divisor,
//   a transfer happens when both are high at a rising clock edge
//   response channel: rsp_valid/rsp_ready with rsp_quotient, rsp_saturated
//   and rsp_divide_by_zero, one response per request, in request order
// throughput and stages
//   one request per cycle sustained while each response is taken; a request
//   goes through one magnitude stage, one restoring stage per quotient bit
//   and one sign and clamp stage that is the output register
// stall behavior
//   the whole pipeline moves together; when the output register holds a
//   result that is not taken, every stage holds and req_ready drops, so
//   nothing is lost or repeated; bubbles move on while the output is empty
// reset
//   synchronous active-high reset clears all stage valid bits; data
//   registers are not reset
// special cases
//   minimum over minus one clamps to maximum with rsp_saturated set; a zero
//   divisor saturates by dividend sign with both flags set
// ----------------------------------------------------------------------------
module signed_restoring_divider #(
   parameter int WIDTH = sdiv_pkg::WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WIDTH-1:0]  req_dividend,
   input  logic signed [WIDTH-1:0]  req_divisor,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WIDTH-1:0]  rsp_quotient,
   output logic                     rsp_saturated,
   output logic                     rsp_divide_by_zero
);

   // global pipeline enable: output empty or being taken this cycle
   logic advance;

   // stage k feeds stage k+1; index 0 is the magnitude stage output
   sdiv_pkg::ctrl_type ctrl_s [0:WIDTH];
   logic [WIDTH-1:0]   rem_s  [0:WIDTH];
   logic [WIDTH-1:0]   a_s    [0:WIDTH];
   logic [WIDTH-1:0]   b_s    [0:WIDTH];
   logic [WIDTH-1:0]   q_s    [0:WIDTH];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // magnitudes, result sign and zero divisor flag
   sdiv_prep #(
      .WIDTH (WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .take     (req_valid),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .ctrl_out (ctrl_s[0]),
      .a_out    (a_s[0]),
      .b_out    (b_s[0])
   );

   // partial remainder and quotient start at zero
   assign rem_s[0] = '0;
   assign q_s[0]   = '0;

   // one restoring step per quotient bit, msb first
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      sdiv_stage #(
         .WIDTH (WIDTH),
         .BIT   (WIDTH - 1 - k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_ctrl (ctrl_s[k]),
         .prev_rem  (rem_s[k]),
         .prev_a    (a_s[k]),
         .prev_b    (b_s[k]),
         .prev_q    (q_s[k]),
         .ctrl_out  (ctrl_s[k+1]),
         .rem_out   (rem_s[k+1]),
         .a_out     (a_s[k+1]),
         .b_out     (b_s[k+1]),
         .q_out     (q_s[k+1])
      );
   end

   // sign, clamp and output register
   sdiv_post #(
      .WIDTH (WIDTH)
   ) u_post (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .prev_ctrl     (ctrl_s[WIDTH]),
      .prev_q        (q_s[WIDTH]),
      .valid_out     (rsp_valid),
      .quotient_out  (rsp_quotient),
      .saturated_out (rsp_saturated),
      .zero_div_out  (rsp_divide_by_zero)
   );

endmodule

>>> dv/tb_signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// tb_signed_restoring_divider
// self-checking bench for the pipelined signed divider: a queue-fed driver
// sends dividend/divisor pairs, a monitor predicts each quotient and its flags
// on the request transfer and checks responses in order, under three idling
// patterns on the two channels
// ----------------------------------------------------------------------------
module tb_signed_restoring_divider;

   localparam int W = sdiv_pkg::WIDTH_DEFAULT;
   // used with a margin to size the drain wait at the end
   localparam int PIPE_LATENCY = W + 1;

   typedef logic signed [W-1:0] operand_type;

   typedef struct packed {
      operand_type dividend;
      operand_type divisor;
   } div_request_type;

   typedef struct packed {
      operand_type quotient;
      logic        saturated;
      logic        divide_by_zero;
   } div_result_type;

   localparam operand_type MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam operand_type MAX_VAL = {1'b0, {(W-1){1'b1}}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   operand_type req_dividend = '0;
   operand_type req_divisor = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   operand_type rsp_quotient;
   logic        rsp_saturated;
   logic        rsp_divide_by_zero;

   // stimulus side
   div_request_type div_requests[$];     // pairs waiting to be driven
   div_request_type next_req;
   int              queued_count = 0;    // pairs handed to the driver so far
   int              accepted_count = 0;  // request transfers seen
   logic            req_taken = 1'b0;    // request transfer at the last rising edge
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;

   // checking side
   div_result_type  expected_quotients[$];
   div_result_type  want;
   int              error_count = 0;

   signed_restoring_divider #(.WIDTH(W)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // restoring division of the magnitudes, then sign fix-up and clamp
   function automatic div_result_type divide_truncated(operand_type num, operand_type den);
      logic [W-1:0]   mag_num;
      logic [W-1:0]   mag_den;
      logic [W:0]     partial;
      logic [W-1:0]   quo;
      logic           flip;
      div_result_type res;
      // negating the minimum leaves the same bits, read unsigned that is 2^(W-1)
      mag_num = num[W-1] ? -num : num;
      mag_den = den[W-1] ? -den : den;
      flip    = num[W-1] ^ den[W-1];
      partial = '0;
      quo     = '0;
      for (int i = W - 1; i >= 0; i--) begin
         partial = {partial[W-1:0], mag_num[i]};
         if (partial >= {1'b0, mag_den}) begin
            partial = partial - {1'b0, mag_den};
            quo[i]  = 1'b1;
         end
      end
      res.saturated = 1'b0;
      if (flip) begin
         if (quo > MIN_VAL) begin
            quo = MIN_VAL;
            res.saturated = 1'b1;
         end
         res.quotient = -quo;
      end else begin
         if (quo > MAX_VAL) begin
            quo = MAX_VAL;
            res.saturated = 1'b1;
         end
         res.quotient = quo;
      end
      // zero divisor sets every quotient bit, so the clamp above always fires
      res.divide_by_zero = (mag_den == '0);
      return res;
   endfunction

   // operand mix: edge values, small numbers, random-width values and full-range noise
   function automatic operand_type pick_operand();
      operand_type v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: v = '0;
               1: v = 1;
               2: v = -1;
               3: v = MIN_VAL;
               4: v = MAX_VAL;
               default: v = MIN_VAL + 1;
            endcase
         end
         1, 2: v = $signed($urandom_range(200)) - 100;
         3, 4: begin
            v = $urandom >> $urandom_range(W - 1);
            if ($urandom_range(1)) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic void queue_pair(operand_type num, operand_type den);
      div_request_type r;
      r.dividend = num;
      r.divisor  = den;
      div_requests.push_back(r);
      queued_count++;
   endfunction

   task automatic note_error(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // driver: new pair or idle at the falling edge, held until transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (div_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req      = div_requests.pop_front();
            req_valid    <= 1'b1;
            req_dividend <= next_req.dividend;
            req_divisor  <= next_req.divisor;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: check the response first so a same-edge request cannot match it
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_quotients.size() == 0) begin
               note_error($sformatf("response %0d with no request outstanding",
                                    rsp_quotient));
            end else begin
               want = expected_quotients.pop_front();
               if (rsp_quotient !== want.quotient)
                  note_error($sformatf("quotient %0d, expected %0d",
                                       rsp_quotient, want.quotient));
               if (rsp_saturated !== want.saturated)
                  note_error($sformatf("saturated %b, expected %b",
                                       rsp_saturated, want.saturated));
               if (rsp_divide_by_zero !== want.divide_by_zero)
                  note_error($sformatf("divide_by_zero %b, expected %b",
                                       rsp_divide_by_zero, want.divide_by_zero));
            end
         end
         if (req_valid && req_ready) begin
            expected_quotients.push_back(divide_truncated(req_dividend, req_divisor));
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver stalls half the time
      send_idle_pct = 9;
      rsp_stall_pct = 50;

      // directed: signs, zero divisor, min over minus one, range extremes
      queue_pair(0, 1);
      queue_pair(1, 0);
      queue_pair(-1, 0);
      queue_pair(0, 0);
      queue_pair(MIN_VAL, 0);
      queue_pair(MAX_VAL, 0);
      queue_pair(MIN_VAL, -1);
      queue_pair(MIN_VAL, 1);
      queue_pair(MIN_VAL, MIN_VAL);
      queue_pair(MAX_VAL, MAX_VAL);
      queue_pair(MAX_VAL, -1);
      queue_pair(MIN_VAL, MAX_VAL);
      queue_pair(MAX_VAL, MIN_VAL);
      queue_pair(MAX_VAL, 1);
      queue_pair(1, MIN_VAL);
      queue_pair(-1, -1);
      queue_pair(7, 2);
      queue_pair(-7, 2);
      queue_pair(7, -2);
      queue_pair(-7, -2);
      queue_pair(5, 7);
      queue_pair(100, -3);
      queue_pair(-1, MAX_VAL);

      repeat (170) queue_pair(pick_operand(), pick_operand());
      wait (accepted_count == queued_count);

      // sender idles half the time, receiver mostly ready
      send_idle_pct = 50;
      rsp_stall_pct = 9;
      repeat (165) queue_pair(pick_operand(), pick_operand());
      wait (accepted_count == queued_count);

      // back to back, no idling on either side
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (165) queue_pair(pick_operand(), pick_operand());
      wait (accepted_count == queued_count);

      wait (expected_quotients.size() == 0);
      // catch any stray response trailing the last one
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
